@@ sv/alsr_pkg.sv @@
`timescale 1ns / 1ps
// alsr_pkg: shared types and constants of the adaptive lru / srrip replacement engine
// no dependencies; imported by alsr_set_mem and adaptive_lru_srrip_replacement

package alsr_pkg;

    // default geometry
    localparam int DEF_NUM_SETS = 2048;
    localparam int DEF_NUM_WAYS = 16;
    localparam int DEF_WINDOW   = 128;

    // field widths of the command and result beats
    localparam int SET_IDX_W = 11;
    localparam int WAY_FLD_W = 4;

    // rrip constants
    localparam logic [1:0] RRPV_MAX   = 2'd3;
    localparam logic [1:0] RRPV_RESET = 2'd2;

    // configuration register reset values
    localparam logic [7:0] MISS_LIMIT_RESET  = 8'd44;
    localparam logic [1:0] INSERT_RRPV_RESET = 2'd2;

    // configuration register indexes
    localparam logic CFG_MISS_LIMIT  = 1'b0;
    localparam logic CFG_INSERT_RRPV = 1'b1;

    // command codes
    localparam logic CMD_FIND_VICTIM = 1'b0;
    localparam logic CMD_UPDATE      = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_FLD_W-1:0] way;
        logic                 hit;
    } t_cmd_in;

    typedef struct packed {
        logic [WAY_FLD_W-1:0] victim_way;
        logic                 set_policy;
    } t_res_out;

    // request from the sequencer to the set memory
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_req;

endpackage

@@ sv/adaptive_lru_srrip_replacement.sv @@
`timescale 1ns / 1ps
// adaptive_lru_srrip_replacement: top level of the per-set lru / srrip replacement engine
// depends on alsr_pkg and alsr_set_mem

// Per-set replacement engine. A command beat is taken when start is high and busy is
// low; each command gives exactly one result beat, shown on o_res for one cycle with
// o_strobe high. The receiver cannot stall: the beat must be taken in that cycle. Each
// command is a read-modify-write of one set entry in a synchronous memory; for a find-victim
// command or an update under lru, the ways of the set are walked one per cycle through a
// single shared comparator between the read and the write-back. An update under srrip, or
// to a way beyond NUM_WAYS, skips that walk. When NUM_SETS is neither a power of two nor at
// least 2048, the set index is first reduced by a reciprocal multiplication in S_MOD and
// S_REM. After reset the memory is swept one set per cycle, during which busy stays high;
// configuration writes are taken at any time.

module adaptive_lru_srrip_replacement #(
    parameter int NUM_SETS = alsr_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = alsr_pkg::DEF_NUM_WAYS,
    parameter int WINDOW   = alsr_pkg::DEF_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  alsr_pkg::t_cmd_in  i_cmd,
    // result channel
    output logic               o_strobe,
    output alsr_pkg::t_res_out o_res,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import alsr_pkg::*;

    // widths
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int POS_W = WAY_W;
    localparam int CMP_W = (POS_W > 2) ? POS_W : 2;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LIM_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int XW    = (SET_W > SET_IDX_W) ? SET_W : SET_IDX_W;

    // reciprocal for the set index reduction: exact quotient for every 11-bit index
    localparam int     RCP_L  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
    localparam int     RCP_SH = SET_IDX_W + RCP_L;
    localparam int     RCP_W  = SET_IDX_W + 2;
    localparam int     PRD_W  = SET_IDX_W + RCP_W;
    localparam int     QN_W   = SET_IDX_W + SET_W + 1;
    localparam longint RCP_M  = ((longint'(1) << RCP_SH) + longint'(NUM_SETS) - 1) /
                                longint'(NUM_SETS);

    // set entry layout: policy | positions | rrpvs | access count | miss count
    localparam int MISS_LSB = 0;
    localparam int ACC_LSB  = CNT_W;
    localparam int RRPV_LSB = 2 * CNT_W;
    localparam int POS_LSB  = RRPV_LSB + 2 * NUM_WAYS;
    localparam int POL_BIT  = POS_LSB + POS_W * NUM_WAYS;
    localparam int ENTRY_W  = POL_BIT + 1;

    // index can be used as is when it is always in range or the set count is a power of two
    localparam bit DIRECT_IDX = (NUM_SETS >= (1 << SET_IDX_W)) ||
                                ((NUM_SETS > 1) && ((NUM_SETS & (NUM_SETS - 1)) == 0));

    function automatic logic [ENTRY_W-1:0] f_reset_entry();
        logic [ENTRY_W-1:0] e;
        e = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            e[POS_LSB + w * POS_W +: POS_W] = POS_W'(w);
            e[RRPV_LSB + 2 * w +: 2]        = RRPV_RESET;
        end
        return e;
    endfunction

    localparam logic [ENTRY_W-1:0] RESET_ENTRY = f_reset_entry();

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_REM,
        S_READ,
        S_LOAD,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef enum logic [2:0] {
        OP_LRU_VIC,
        OP_RRIP_VIC,
        OP_LRU_UPD,
        OP_RRIP_UPD,
        OP_SKIP
    } t_op;

    // sequencer and output registers
    t_state   r_state, n_state;
    logic     r_strobe, n_strobe;
    t_res_out r_res, n_res;

    // configuration registers
    logic [7:0] r_miss_limit;
    logic [1:0] r_insert;

    // working registers for the set under service
    t_cmd_in                        r_in, n_in;
    logic [SET_IDX_W-1:0]           r_quo, n_quo;
    logic [SET_W-1:0]               r_addr, n_addr;
    logic [NUM_WAYS-1:0][POS_W-1:0] r_pos, n_pos;
    logic [NUM_WAYS-1:0][1:0]       r_rrpv, n_rrpv;
    logic                           r_policy, n_policy;
    logic [CNT_W-1:0]               r_acc, n_acc;
    logic [CNT_W-1:0]               r_miss, n_miss;
    t_op                            r_op, n_op;
    logic [CMP_W-1:0]               r_ref, n_ref;   // best position, largest rrpv, or hit position
    logic [WAY_W-1:0]               r_vic, n_vic;
    logic [WAY_W-1:0]               r_w, n_w;

    // memory interface
    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               mem_clearing;

    // unpacked read data
    logic [NUM_WAYS-1:0][POS_W-1:0] ld_pos;
    logic [NUM_WAYS-1:0][1:0]       ld_rrpv;
    logic                           ld_policy;
    logic [CNT_W-1:0]               ld_acc;
    logic [CNT_W-1:0]               ld_miss;

    // write-back values
    logic [NUM_WAYS-1:0][POS_W-1:0] wr_pos;
    logic [NUM_WAYS-1:0][1:0]       wr_rrpv;
    logic [1:0]                     age_add;

    // shared comparator
    logic [CMP_W-1:0] cmp_a, cmp_b;
    logic             cmp_lt;
    logic [POS_W-1:0] elem_pos;
    logic [1:0]       elem_rrpv;

    // helpers
    logic [XW-1:0]    idx_ext;
    logic [PRD_W-1:0] quo_prod;
    logic [QN_W-1:0]  rem_full;
    logic [5:0]       way_ext;
    logic [WAY_W-1:0] way_idx;
    logic             way_ok;
    logic [5:0]       vic_ext;
    logic [CNT_W-1:0] acc_inc, miss_inc;
    logic             win_end, win_srrip;

    alsr_set_mem #(
        .NUM_SETS    (NUM_SETS),
        .SET_W       (SET_W),
        .ENTRY_W     (ENTRY_W),
        .RESET_ENTRY (RESET_ENTRY)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .i_addr     (r_addr),
        .i_wdata    (mem_wdata),
        .o_rdata    (mem_rdata),
        .o_clearing (mem_clearing)
    );

    assign busy     = (r_state != S_IDLE) || mem_clearing;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    assign idx_ext = XW'(i_cmd.set_index);
    assign way_ext = {2'b00, r_in.way};
    assign way_idx = way_ext[WAY_W-1:0];
    assign way_ok  = way_ext < 6'(NUM_WAYS);
    assign vic_ext = 6'(r_vic);

    // index reduction: quotient by reciprocal, then remainder by one multiply-subtract
    assign quo_prod = PRD_W'(r_in.set_index) * PRD_W'(RCP_M);
    assign rem_full = QN_W'(r_in.set_index) - QN_W'(r_quo) * QN_W'(NUM_SETS);

    // window bookkeeping for an update, on the freshly read counters
    assign acc_inc   = ld_acc + CNT_W'(1);
    assign miss_inc  = ld_miss + {{(CNT_W - 1){1'b0}}, ~r_in.hit};
    assign win_end   = acc_inc >= CNT_W'(WINDOW);
    assign win_srrip = LIM_W'(miss_inc) > LIM_W'(r_miss_limit);

    // unpack the entry as it comes from memory
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            ld_pos[w]  = mem_rdata[POS_LSB + w * POS_W +: POS_W];
            ld_rrpv[w] = mem_rdata[RRPV_LSB + 2 * w +: 2];
        end
        ld_policy = mem_rdata[POL_BIT];
        ld_acc    = mem_rdata[ACC_LSB +: CNT_W];
        ld_miss   = mem_rdata[MISS_LSB +: CNT_W];
    end

    // one comparator serves every scan: victim search, rrpv maximum, stack demotion
    always_comb begin
        elem_pos  = r_pos[r_w];
        elem_rrpv = r_rrpv[r_w];
        case (r_op)
            OP_RRIP_VIC: begin
                cmp_a = r_ref;
                cmp_b = CMP_W'(elem_rrpv);
            end
            default: begin
                cmp_a = CMP_W'(elem_pos);
                cmp_b = r_ref;
            end
        endcase
        cmp_lt = cmp_a < cmp_b;
    end

    // final touch on the entry before write-back
    always_comb begin
        age_add = RRPV_MAX - r_ref[1:0];
        wr_pos  = r_pos;
        wr_rrpv = r_rrpv;
        case (r_op)
            OP_LRU_UPD: begin
                wr_pos[way_idx] = '0;
            end
            OP_RRIP_UPD: begin
                wr_rrpv[way_idx] = r_in.hit ? 2'd0 : r_insert;
            end
            OP_RRIP_VIC: begin
                // age the whole set so the oldest entries reach the maximum
                for (int w = 0; w < NUM_WAYS; w++) begin
                    wr_rrpv[w] = r_rrpv[w] + age_add;
                end
            end
            default: ;
        endcase
        for (int w = 0; w < NUM_WAYS; w++) begin
            mem_wdata[POS_LSB + w * POS_W +: POS_W] = wr_pos[w];
            mem_wdata[RRPV_LSB + 2 * w +: 2]        = wr_rrpv[w];
        end
        mem_wdata[POL_BIT]            = r_policy;
        mem_wdata[ACC_LSB +: CNT_W]   = r_acc;
        mem_wdata[MISS_LSB +: CNT_W]  = r_miss;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_in     = r_in;
        n_quo    = r_quo;
        n_addr   = r_addr;
        n_pos    = r_pos;
        n_rrpv   = r_rrpv;
        n_policy = r_policy;
        n_acc    = r_acc;
        n_miss   = r_miss;
        n_op     = r_op;
        n_ref    = r_ref;
        n_vic    = r_vic;
        n_w      = r_w;
        mem_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (start && !mem_clearing) begin
                    n_in = i_cmd;
                    if (DIRECT_IDX) begin
                        n_addr  = idx_ext[SET_W-1:0];
                        n_state = S_READ;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // quotient of the set index by the set count
                n_quo   = SET_IDX_W'(quo_prod >> RCP_SH);
                n_state = S_REM;
            end
            S_REM: begin
                n_addr  = rem_full[SET_W-1:0];
                n_state = S_READ;
            end
            S_READ: begin
                mem_req.rd = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                n_pos    = ld_pos;
                n_rrpv   = ld_rrpv;
                n_policy = ld_policy;
                n_acc    = ld_acc;
                n_miss   = ld_miss;
                n_w      = '0;
                n_vic    = '0;
                n_ref    = '0;
                n_state  = S_SCAN;
                if (r_in.command == CMD_FIND_VICTIM) begin
                    n_op = ld_policy ? OP_RRIP_VIC : OP_LRU_VIC;
                end else begin
                    if (win_end) begin
                        n_policy = win_srrip;
                        n_acc    = '0;
                        n_miss   = '0;
                    end else begin
                        n_acc  = acc_inc;
                        n_miss = miss_inc;
                    end
                    if (!way_ok) begin
                        n_op    = OP_SKIP;
                        n_state = S_WRITE;
                    end else if (n_policy) begin
                        n_op    = OP_RRIP_UPD;
                        n_state = S_WRITE;
                    end else begin
                        n_op  = OP_LRU_UPD;
                        n_ref = CMP_W'(ld_pos[way_idx]);
                    end
                end
            end
            S_SCAN: begin
                case (r_op)
                    OP_LRU_VIC: begin
                        // ties go to the higher way
                        if (!cmp_lt) begin
                            n_ref = CMP_W'(elem_pos);
                            n_vic = r_w;
                        end
                    end
                    OP_RRIP_VIC: begin
                        // strict compare keeps the first way holding the maximum
                        if (cmp_lt) begin
                            n_ref = CMP_W'(elem_rrpv);
                            n_vic = r_w;
                        end
                    end
                    OP_LRU_UPD: begin
                        if (cmp_lt) begin
                            n_pos[r_w] = elem_pos + POS_W'(1);
                        end
                    end
                    default: ;
                endcase
                if (r_w == WAY_W'(NUM_WAYS - 1)) begin
                    n_state = S_WRITE;
                end else begin
                    n_w = r_w + WAY_W'(1);
                end
            end
            S_WRITE: begin
                mem_req.wr       = 1'b1;
                n_strobe         = 1'b1;
                n_res.victim_way = vic_ext[WAY_FLD_W-1:0];
                n_res.set_policy = r_policy;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_res    <= n_res;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_LIMIT_RESET;
            r_insert     <= INSERT_RRPV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MISS_LIMIT:  r_miss_limit <= i_cfg_data;
                CFG_INSERT_RRPV: r_insert     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_quo    <= n_quo;
        r_addr   <= n_addr;
        r_pos    <= n_pos;
        r_rrpv   <= n_rrpv;
        r_policy <= n_policy;
        r_acc    <= n_acc;
        r_miss   <= n_miss;
        r_op     <= n_op;
        r_ref    <= n_ref;
        r_vic    <= n_vic;
        r_w      <= n_w;
    end

`ifndef SYNTH
    // a result beat follows only a write-back
    a_strobe_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_WRITE))
        else $error("result beat without write-back");

    // a result beat lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beat held longer than one cycle");

    // only searches and lru demotion walk the ways
    a_scan_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_op == OP_LRU_VIC || r_op == OP_RRIP_VIC ||
                                 r_op == OP_LRU_UPD))
        else $error("way scan entered for an operation that needs none");

    // no command is taken during the clearing sweep
    a_no_start_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_clearing && r_state == S_IDLE) |=> (r_state == S_IDLE))
        else $error("command taken during clearing sweep");
`endif

endmodule

@@ sv/alsr_set_mem.sv @@
`timescale 1ns / 1ps
// alsr_set_mem: per-set state memory with a clearing sweep after reset
// depends on alsr_pkg (t_mem_req)

module alsr_set_mem #(
    parameter int                 NUM_SETS    = alsr_pkg::DEF_NUM_SETS,
    parameter int                 SET_W       = 11,
    parameter int                 ENTRY_W     = 113,
    parameter logic [ENTRY_W-1:0] RESET_ENTRY = '0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alsr_pkg::t_mem_req  i_req,
    input  logic [SET_W-1:0]    i_addr,
    input  logic [ENTRY_W-1:0]  i_wdata,
    output logic [ENTRY_W-1:0]  o_rdata,
    output logic                o_clearing
);
    import alsr_pkg::*;

    logic [ENTRY_W-1:0] r_mem [NUM_SETS];
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_clearing;
    logic [SET_W-1:0]   r_clr_addr;

    // sweep one set per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= RESET_ENTRY;
        end else if (i_req.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule
